>>> hdl/skts_pkg.sv
package skts_pkg;

    // Fixed field widths of the request and response words.
    localparam int KEY_W = 64;
    localparam int IDX_W = 12;
    localparam int POS_W = 13;
    localparam int CNT_W = 13;
    localparam int SUB_W = 16;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_FIND    = 2'd1,
        OP_FIND_FB = 2'd2,
        OP_RANGE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SEARCH,
        ST_END,
        ST_VERIFY,
        ST_RESULT
    } state_t;

    // Which search of a request is running.
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_RETRY,
        PH_SECOND
    } phase_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] index;
        logic [KEY_W-1:0] key_value;
        logic [KEY_W-1:0] high_key;
    } req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] range_end;
    } rsp_t;

endpackage

>>> hdl/skts_key_mem.sv
module skts_key_mem
    import skts_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    // Single write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data appears in the cycle after rd_en.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/skts_ctrl.sv
module skts_ctrl
    import skts_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096,
    parameter int AW          = 12,
    parameter int CW          = 13
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Request word.
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_req,
    // Active entry count, already limited to the table depth.
    input  logic [CW-1:0]    count,
    // Table memory.
    output logic             mem_wr_en,
    output logic [AW-1:0]    mem_wr_addr,
    output logic [KEY_W-1:0] mem_wr_data,
    output logic             mem_rd_en,
    output logic [AW-1:0]    mem_rd_addr,
    input  logic [KEY_W-1:0] mem_rd_data,
    // Response word.
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_t             rsp
);

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    req_t             req_reg, req_next;
    logic [CW-1:0]    lo_reg, lo_next;
    logic [CW-1:0]    hi_reg, hi_next;
    logic [CW-1:0]    mid_reg, mid_next;
    logic [KEY_W-1:0] bound_reg, bound_next;
    logic             incl_reg, incl_next;
    logic             found_reg, found_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    end_reg, end_next;

    logic [CW-1:0]    mid_cur;
    logic [CW-1:0]    lo_new, hi_new, mid_new;
    logic             go_right;
    logic             retry_ok;
    logic             miss;
    logic             wr_in_range;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Search registers and the pending request.
    always_ff @(posedge aclk) begin
        phase_reg <= phase_next;
        req_reg   <= req_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        bound_reg <= bound_next;
        incl_reg  <= incl_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        end_reg   <= end_next;
    end

    // Midpoint of the current interval and the interval after this probe.
    assign mid_cur  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign go_right = incl_reg ? (mem_rd_data <= bound_reg) : (mem_rd_data < bound_reg);
    assign lo_new   = go_right ? (mid_reg + CW'(1)) : lo_reg;
    assign hi_new   = go_right ? hi_reg : mid_reg;
    assign mid_new  = lo_new + ((hi_new - lo_new) >> 1);

    // A fallback search runs once, only for a fallback find whose key has nonzero low SUB_W bits.
    assign retry_ok = (req_reg.op == OP_FIND_FB) && (phase_reg == PH_FIRST) &&
                      (req_reg.key_value[SUB_W-1:0] != '0);

    assign wr_in_range = (32'(s_req.index) < 32'(MAX_ENTRIES));

    assign mem_wr_addr = AW'(s_req.index);
    assign mem_wr_data = s_req.key_value;

    assign rsp.found     = found_reg;
    assign rsp.position  = POS_W'(pos_reg);
    assign rsp.range_end = POS_W'(end_reg);

    // Next state and memory access sequencing.
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        req_next    = req_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        bound_next  = bound_reg;
        incl_next   = incl_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        end_next    = end_reg;
        s_ready     = 1'b0;
        rsp_valid   = 1'b0;
        mem_wr_en   = 1'b0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = mid_cur[AW-1:0];
        miss        = 1'b0;

        case (state_reg)
            // No word is taken while reset is held.
            ST_IDLE: begin
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    req_next   = s_req;
                    lo_next    = '0;
                    hi_next    = count;
                    bound_next = s_req.key_value;
                    incl_next  = 1'b0;
                    phase_next = PH_FIRST;
                    found_next = 1'b0;
                    pos_next   = '0;
                    end_next   = '0;
                    if (s_req.op == OP_WRITE) begin
                        mem_wr_en  = wr_in_range;
                        state_next = ST_RESULT;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end

            ST_START: begin
                if (lo_reg < hi_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mid_cur[AW-1:0];
                    mid_next    = mid_cur;
                    state_next  = ST_SEARCH;
                end else begin
                    state_next = ST_END;
                end
            end

            // One probe per cycle: compare the key read back, then fetch the next midpoint.
            ST_SEARCH: begin
                lo_next = lo_new;
                hi_next = hi_new;
                if (lo_new < hi_new) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = mid_new[AW-1:0];
                    mid_next    = mid_new;
                end else begin
                    state_next = ST_END;
                end
            end

            ST_END: begin
                if (req_reg.op == OP_RANGE) begin
                    if (phase_reg == PH_FIRST) begin
                        // The end search starts at the first index of the range.
                        pos_next   = lo_reg;
                        hi_next    = count;
                        bound_next = req_reg.high_key;
                        incl_next  = 1'b1;
                        phase_next = PH_SECOND;
                        state_next = ST_START;
                    end else begin
                        end_next   = lo_reg;
                        state_next = ST_RESULT;
                    end
                end else if (lo_reg < count) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = lo_reg[AW-1:0];
                    state_next  = ST_VERIFY;
                end else begin
                    miss = 1'b1;
                end
            end

            ST_VERIFY: begin
                if (mem_rd_data == bound_reg) begin
                    found_next = 1'b1;
                    pos_next   = lo_reg;
                    state_next = ST_RESULT;
                end else begin
                    miss = 1'b1;
                end
            end

            ST_RESULT: begin
                rsp_valid = 1'b1;
                if (rsp_ready) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A find that missed either retries with the low part cleared or reports a miss.
        if (miss) begin
            if (retry_ok) begin
                bound_next = {req_reg.key_value[KEY_W-1:SUB_W], {SUB_W{1'b0}}};
                lo_next    = '0;
                hi_next    = count;
                phase_next = PH_RETRY;
                state_next = ST_START;
            end else begin
                found_next = 1'b0;
                pos_next   = '0;
                state_next = ST_RESULT;
            end
        end
    end

endmodule

>>> hdl/sorted_key_table_search.sv
// Sorted key table with lower-bound search.
// Keys are loaded through the request channel (op write) at any table index;
// entry_count, written through cfg_wr_en/cfg_wr_data, sets how many leading
// entries are searched and is limited to MAX_ENTRIES. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Requests arrive on s_valid/s_ready/s_req and each one yields exactly one
// response word on m_valid/m_ready/m_rsp, in request order.
// One request is worked on at a time. The table is a single-port-read memory
// with a registered read port, and the search issues one probe per cycle.
// A write goes straight to its response; an exact find runs one search and
// at most one check of the key found; a fallback find up to two of each; a
// range query runs two searches back to back. The next request is accepted
// once the response has been passed to the output register.
// A finished response waits in the output register; the next request is
// accepted meanwhile, and its own response holds until that register frees.
// Reset clears the control state, the output valid and entry_count and keeps
// s_ready low; the table contents are left as they are and must be written.
module sorted_key_table_search
    import skts_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  req_t             s_req,
    output logic             m_valid,
    input  logic             m_ready,
    output rsp_t             m_rsp
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic [CNT_W-1:0] entry_count_reg;
    logic [CW-1:0]    count;
    logic             mem_wr_en;
    logic [AW-1:0]    mem_wr_addr;
    logic [KEY_W-1:0] mem_wr_data;
    logic             mem_rd_en;
    logic [AW-1:0]    mem_rd_addr;
    logic [KEY_W-1:0] mem_rd_data;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_t             rsp;
    logic             m_valid_reg;
    rsp_t             m_rsp_reg;

    // Entry count register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= '0;
        end else if (cfg_wr_en) begin
            entry_count_reg <= cfg_wr_data;
        end
    end

    // Searches never run past the table depth.
    always_comb begin
        if (32'(entry_count_reg) > 32'(MAX_ENTRIES)) begin
            count = CW'(MAX_ENTRIES);
        end else begin
            count = CW'(entry_count_reg);
        end
    end

    skts_key_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    skts_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .count       (count),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    // Output register; it takes a new word when empty or being drained.
    assign rsp_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (rsp_ready) begin
            m_valid_reg <= rsp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rsp_valid && rsp_ready) begin
            m_rsp_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule
